@@ rtl/core/fbp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Block pool package
// Shared widths, status codes and register map of the free-list block pool.
// ----------------------------------------------------------------------------
package fbp_pkg;

   localparam int DEF_POOL_DEPTH     = 256;
   localparam int DEF_INITIAL_BLOCKS = 16;

   localparam int INDEX_W  = 8;
   localparam int COUNT_W  = 9;
   localparam int STATUS_W = 2;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [0:0] REG_GROWTH_FIXED = 1'b0;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EXHAUSTED = 2'd1,
      STATUS_REJECTED  = 2'd2
   } status_type;

endpackage
`default_nettype wire

@@ rtl/core/fbp_req_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Block pool request channel
// Carries one allocate or free item with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface fbp_req_if;
   logic                        valid;
   logic                        ready;
   logic                        kind;
   logic [fbp_pkg::INDEX_W-1:0] block_index;

   modport source (output valid, output kind, output block_index, input ready);
   modport sink   (input valid, input kind, input block_index, output ready);
endinterface
`default_nettype wire

@@ rtl/core/fbp_rsp_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Block pool response channel
// Carries one result item with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface fbp_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [fbp_pkg::STATUS_W-1:0] status;
   logic [fbp_pkg::INDEX_W-1:0]  granted_index;
   logic [fbp_pkg::COUNT_W-1:0]  live_count;
   logic [fbp_pkg::COUNT_W-1:0]  capacity_now;

   modport source (output valid, output status, output granted_index,
                   output live_count, output capacity_now, input ready);
   modport sink   (input valid, input status, input granted_index,
                   input live_count, input capacity_now, output ready);
endinterface
`default_nettype wire

@@ rtl/core/fbp_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Block pool sequencer
// Holds the link memory, the list head and the counters, and steps one item
// at a time through decide, grow, fetch and pop.
// ----------------------------------------------------------------------------
module fbp_ctrl #(
   parameter int POOL_DEPTH     = fbp_pkg::DEF_POOL_DEPTH,
   parameter int INITIAL_BLOCKS = fbp_pkg::DEF_INITIAL_BLOCKS
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     growth_fixed,
   fbp_req_if.sink       req,
   fbp_rsp_if.source     rsp
);

   localparam int IDX_W = $clog2(POOL_DEPTH);
   localparam int CNT_W = $clog2(POOL_DEPTH + 1);
   localparam int CMP_W = (CNT_W > fbp_pkg::INDEX_W) ? CNT_W : fbp_pkg::INDEX_W;
   localparam int DBL_W = CNT_W + 2;
   localparam int INIT_CLAMP = (INITIAL_BLOCKS < POOL_DEPTH) ? INITIAL_BLOCKS : POOL_DEPTH;
   localparam logic [CNT_W-1:0] INIT_CAP  = CNT_W'(INIT_CLAMP);
   localparam logic [DBL_W-1:0] DEPTH_DBL = DBL_W'(POOL_DEPTH);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_DECIDE = 6'b000010,
      S_GROW   = 6'b000100,
      S_FETCH  = 6'b001000,
      S_POP    = 6'b010000,
      S_DONE   = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic                        kind_ff, kind_in;
   logic [fbp_pkg::INDEX_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0]            head_ff, head_in;
   logic [CNT_W-1:0]            used_ff, used_in;
   logic [CNT_W-1:0]            cap_ff, cap_in;
   logic [CNT_W-1:0]            sweep_ff, sweep_in;
   logic [CNT_W-1:0]            tgt_ff, tgt_in;
   fbp_pkg::status_type         res_status_ff, res_status_in;
   logic [fbp_pkg::INDEX_W-1:0] res_granted_ff, res_granted_in;

   logic                         out_valid_ff, out_valid_in;
   fbp_pkg::status_type          out_status_ff, out_status_in;
   logic [fbp_pkg::INDEX_W-1:0]  out_granted_ff, out_granted_in;
   logic [fbp_pkg::COUNT_W-1:0]  out_live_ff, out_live_in;
   logic [fbp_pkg::COUNT_W-1:0]  out_cap_ff, out_cap_in;

   logic [CNT_W-1:0] link_mem [POOL_DEPTH];
   logic [CNT_W-1:0] rd_data_ff;
   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   logic [CNT_W-1:0] mem_wdata;
   logic             mem_re;

   logic [CMP_W-1:0] idx_ext;
   logic [CMP_W-1:0] cap_ext;
   logic [CMP_W-1:0] head_ext;
   logic [DBL_W-1:0] dbl_sum;
   logic [DBL_W-1:0] dbl_cap;
   logic [DBL_W-1:0] grow_lim;
   logic [CNT_W-1:0] target;
   logic [CNT_W-1:0] sweep_next;
   logic             out_load;

   assign idx_ext  = CMP_W'(idx_ff);
   assign cap_ext  = CMP_W'(cap_ff);
   assign head_ext = CMP_W'(head_ff);

   assign dbl_sum  = DBL_W'(cap_ff) + DBL_W'(1);
   assign dbl_cap  = {dbl_sum[DBL_W-2:0], 1'b0};
   assign grow_lim = (dbl_cap > DEPTH_DBL) ? DEPTH_DBL : dbl_cap;
   assign target   = growth_fixed ? INIT_CAP :
                     ((grow_lim[CNT_W-1:0] > INIT_CAP) ? grow_lim[CNT_W-1:0] : INIT_CAP);

   assign sweep_next = sweep_ff + CNT_W'(1);
   assign out_load   = (state_ff == S_DONE) && (!out_valid_ff || rsp.ready);

   assign req.ready         = (state_ff == S_IDLE);
   assign rsp.valid         = out_valid_ff;
   assign rsp.status        = out_status_ff;
   assign rsp.granted_index = out_granted_ff;
   assign rsp.live_count    = out_live_ff;
   assign rsp.capacity_now  = out_cap_ff;

   always_comb begin
      state_in       = state_ff;
      kind_in        = kind_ff;
      idx_in         = idx_ff;
      head_in        = head_ff;
      used_in        = used_ff;
      cap_in         = cap_ff;
      sweep_in       = sweep_ff;
      tgt_in         = tgt_ff;
      res_status_in  = res_status_ff;
      res_granted_in = res_granted_ff;
      mem_we         = 1'b0;
      mem_waddr      = idx_ext[IDX_W-1:0];
      mem_wdata      = head_ff;
      mem_re         = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               kind_in  = req.kind;
               idx_in   = req.block_index;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            res_granted_in = '0;
            res_status_in  = fbp_pkg::STATUS_OK;
            if (kind_ff == fbp_pkg::KIND_FREE) begin
               state_in = S_DONE;
               if (idx_ext >= cap_ext || used_ff == '0) begin
                  res_status_in = fbp_pkg::STATUS_REJECTED;
               end else begin
                  mem_we  = 1'b1;
                  head_in = idx_ext[CNT_W-1:0];
                  used_in = used_ff - CNT_W'(1);
               end
            end else if (used_ff >= cap_ff) begin
               if (target <= cap_ff) begin
                  res_status_in = fbp_pkg::STATUS_EXHAUSTED;
                  state_in      = S_DONE;
               end else begin
                  tgt_in   = target;
                  sweep_in = used_ff;
                  state_in = S_GROW;
               end
            end else begin
               state_in = S_FETCH;
            end
         end
         S_GROW: begin
            mem_we    = 1'b1;
            mem_waddr = sweep_ff[IDX_W-1:0];
            mem_wdata = sweep_next;
            sweep_in  = sweep_next;
            if (sweep_next == tgt_ff) begin
               cap_in   = tgt_ff;
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            if (head_ff < cap_ff) begin
               mem_re   = 1'b1;
               state_in = S_POP;
            end else begin
               res_status_in = fbp_pkg::STATUS_EXHAUSTED;
               state_in      = S_DONE;
            end
         end
         S_POP: begin
            res_granted_in = head_ext[fbp_pkg::INDEX_W-1:0];
            head_in        = rd_data_ff;
            used_in        = used_ff + CNT_W'(1);
            state_in       = S_DONE;
         end
         S_DONE: begin
            if (out_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in   = out_valid_ff;
      out_status_in  = out_status_ff;
      out_granted_in = out_granted_ff;
      out_live_in    = out_live_ff;
      out_cap_in     = out_cap_ff;
      if (out_load) begin
         out_valid_in   = 1'b1;
         out_status_in  = res_status_ff;
         out_granted_in = res_granted_ff;
         out_live_in    = fbp_pkg::COUNT_W'(used_ff);
         out_cap_in     = fbp_pkg::COUNT_W'(cap_ff);
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         used_ff      <= '0;
         cap_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         used_ff      <= used_in;
         cap_ff       <= cap_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      idx_ff         <= idx_in;
      sweep_ff       <= sweep_in;
      tgt_ff         <= tgt_in;
      res_status_ff  <= res_status_in;
      res_granted_ff <= res_granted_in;
      out_status_ff  <= out_status_in;
      out_granted_ff <= out_granted_in;
      out_live_ff    <= out_live_in;
      out_cap_ff     <= out_cap_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         link_mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_data_ff <= link_mem[head_ff[IDX_W-1:0]];
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/fixed_block_pool_free_list_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Fixed block pool free list
// Allocates and frees equal-size blocks through an intrusive free list with
// optional capacity growth, configured over an APB-style register port.
// ----------------------------------------------------------------------------
// The block takes one item at a time. A free goes from decide straight to
// the done state, an allocate without growth through decide, fetch and pop,
// and an allocate that grows the pool also through the grow state, since the
// growth sweep writes the link memory one entry per cycle. A result waits in
// an output register, and the next item can be accepted in the cycle after
// the result is loaded, so items never overlap. A finished item whose result
// cannot yet be loaded holds the input off until the output register frees
// up. The link memory needs no clearing pass after reset.
// Register 0 at byte address 0 holds growth_fixed in bit 0.
module fixed_block_pool_free_list_core #(
   parameter int POOL_DEPTH     = fbp_pkg::DEF_POOL_DEPTH,
   parameter int INITIAL_BLOCKS = fbp_pkg::DEF_INITIAL_BLOCKS
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   fbp_req_if.sink                               req,
   fbp_rsp_if.source                             rsp,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [fbp_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [fbp_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic      [fbp_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                  csr_pready
);

   logic growth_fixed_ff, growth_fixed_in;
   logic reg_hit;
   logic csr_write;

   assign reg_hit    = (csr_paddr[fbp_pkg::CSR_ADDR_W-1:2] == fbp_pkg::REG_GROWTH_FIXED);
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = reg_hit ? fbp_pkg::CSR_DATA_W'(growth_fixed_ff) : '0;

   always_comb begin
      growth_fixed_in = growth_fixed_ff;
      if (csr_write && reg_hit) begin
         growth_fixed_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         growth_fixed_ff <= 1'b0;
      end else begin
         growth_fixed_ff <= growth_fixed_in;
      end
   end

   fbp_ctrl #(
      .POOL_DEPTH     (POOL_DEPTH),
      .INITIAL_BLOCKS (INITIAL_BLOCKS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .growth_fixed (growth_fixed_ff),
      .req          (req),
      .rsp          (rsp)
   );

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> !req.ready)
      else $error("request accepted while an item is in progress");

   a_granted_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.status != fbp_pkg::STATUS_OK) |-> (rsp.granted_index == '0))
      else $error("granted index nonzero on a failed item");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.status == fbp_pkg::STATUS_OK ||
                     rsp.status == fbp_pkg::STATUS_EXHAUSTED ||
                     rsp.status == fbp_pkg::STATUS_REJECTED))
      else $error("undefined status code on result");

endmodule
`default_nettype wire

@@ tb/sv/block_pool_tracker_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Block pool tracker
// Scoreboard class that mirrors the free list, the live count and the
// capacity of the block pool, and checks every result item in order.
// ----------------------------------------------------------------------------
package block_pool_tracker_pkg;

   import fbp_pkg::*;

   typedef struct packed {
      status_type          status;
      logic [INDEX_W-1:0]  granted_index;
      logic [COUNT_W-1:0]  live_count;
      logic [COUNT_W-1:0]  capacity_now;
   } pool_result_type;

   class free_list_tracker;
      logic [COUNT_W-1:0] link_word [DEF_POOL_DEPTH];
      logic [COUNT_W-1:0] head_index;
      logic [COUNT_W-1:0] live_blocks;
      logic [COUNT_W-1:0] capacity;
      logic               growth_fixed;
      logic [INDEX_W-1:0] granted_blocks [$];
      pool_result_type    due_results [$];
      int                 errors;

      function new();
         foreach (link_word[i]) link_word[i] = '0;
         head_index   = '0;
         live_blocks  = '0;
         capacity     = '0;
         growth_fixed = 1'b0;
         errors       = 0;
      endfunction

      function bit grow_capacity();
         int target;
         target = (int'(capacity) + 1) * 2;
         if (target < DEF_INITIAL_BLOCKS) target = DEF_INITIAL_BLOCKS;
         if (growth_fixed) target = DEF_INITIAL_BLOCKS;
         if (target > DEF_POOL_DEPTH) target = DEF_POOL_DEPTH;
         if (target <= int'(capacity)) return 1'b0;
         for (int n = int'(live_blocks); n < target; n++) link_word[n] = COUNT_W'(n + 1);
         capacity = COUNT_W'(target);
         return 1'b1;
      endfunction

      function void note_request(logic kind, logic [INDEX_W-1:0] index);
         pool_result_type outcome;
         bit              room;
         outcome        = '0;
         outcome.status = STATUS_OK;
         if (kind == KIND_ALLOC) begin
            room = 1'b1;
            if (live_blocks >= capacity) room = grow_capacity();
            if (room && head_index < capacity) begin
               outcome.granted_index = head_index[INDEX_W-1:0];
               granted_blocks.push_back(head_index[INDEX_W-1:0]);
               head_index  = link_word[head_index[INDEX_W-1:0]];
               live_blocks = live_blocks + COUNT_W'(1);
            end else begin
               outcome.status = STATUS_EXHAUSTED;
            end
         end else if (index >= capacity || live_blocks == 0) begin
            outcome.status = STATUS_REJECTED;
         end else begin
            link_word[index] = head_index;
            head_index       = COUNT_W'(index);
            live_blocks      = live_blocks - COUNT_W'(1);
            foreach (granted_blocks[i]) begin
               if (granted_blocks[i] == index) begin
                  granted_blocks.delete(i);
                  break;
               end
            end
         end
         outcome.live_count   = live_blocks;
         outcome.capacity_now = capacity;
         due_results.push_back(outcome);
      endfunction

      function void check_result(logic [STATUS_W-1:0] status, logic [INDEX_W-1:0] granted,
                                 logic [COUNT_W-1:0] live, logic [COUNT_W-1:0] cap_now);
         pool_result_type wanted;
         if (due_results.size() == 0) begin
            $display("%0t: result item with none expected: st=%0d idx=%0d live=%0d cap=%0d",
                     $time, status, granted, live, cap_now);
            errors++;
            return;
         end
         wanted = due_results.pop_front();
         if ({wanted.status, wanted.granted_index, wanted.live_count, wanted.capacity_now}
             !== {status, granted, live, cap_now}) begin
            $display({"%0t: expected st=%0d idx=%0d live=%0d cap=%0d, ",
                      "got st=%0d idx=%0d live=%0d cap=%0d"},
                     $time, wanted.status, wanted.granted_index, wanted.live_count,
                     wanted.capacity_now, status, granted, live, cap_now);
            errors++;
         end
      endfunction
   endclass

endpackage
`default_nettype wire

@@ tb/sv/tb_fixed_block_pool_free_list_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Block pool free list testbench
// Drives allocate and free items into the pool, predicts every result with
// a tracker of the free list, and checks each result item in order. Runs a
// directed opening, random phases with varying idle and stall patterns and
// growth settings, a long receiver hold-off, and a closing double free.
// ----------------------------------------------------------------------------
module tb_fixed_block_pool_free_list_core;

   import fbp_pkg::*;
   import block_pool_tracker_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_left = 0;

   free_list_tracker pool = new();

   fbp_req_if req ();
   fbp_rsp_if rsp ();

   fixed_block_pool_free_list_core u_top (
      .clock               (clock),
      .reset               (reset),
      .req                 (req),
      .rsp                 (rsp),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #3000000;
      $display("[fixed_block_pool_free_list_core] ERROR");
      $finish;
   end

   initial begin
      rsp.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
            pool.check_result(rsp.status, rsp.granted_index, rsp.live_count, rsp.capacity_now);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   task automatic write_growth_fixed(input logic fixed);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'({REG_GROWTH_FIXED, 2'b00});
      csr_pwdata  <= CSR_DATA_W'(fixed);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      pool.growth_fixed = fixed;
   endtask

   task automatic send_item(input logic kind, input logic [INDEX_W-1:0] index);
      if ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req.valid       <= 1'b1;
      req.kind        <= kind;
      req.block_index <= index;
      do @(posedge clock); while (req.ready !== 1'b1);
      pool.note_request(kind, index);
   endtask

   task automatic wait_for_results();
      int guard;
      guard = 0;
      while (pool.due_results.size() > 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
   endtask

   task automatic run_phase(input logic fixed, input int idle_pct, input int stall_pct,
                            input int alloc_pct, input int count, input int hold);
      int                 pick;
      logic [INDEX_W-1:0] index;
      req.valid <= 1'b0;
      wait_for_results();
      write_growth_fixed(fixed);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      hold_left      = hold;
      for (int n = 0; n < count; n++) begin
         index = INDEX_W'($urandom_range(255));
         if ($urandom_range(99) < alloc_pct) begin
            send_item(KIND_ALLOC, index);
         end else begin
            pick = $urandom_range(99);
            if (pool.granted_blocks.size() > 0 && (pick < 88 || pool.capacity == DEF_POOL_DEPTH))
               index = pool.granted_blocks[$urandom_range(pool.granted_blocks.size() - 1)];
            else if (pool.granted_blocks.size() > 0)
               index = INDEX_W'($urandom_range(255, int'(pool.capacity)));
            send_item(KIND_FREE, index);
         end
      end
   endtask

   initial begin
      logic [INDEX_W-1:0] victim;
      int                 guard;
      req.valid       = 1'b0;
      req.kind        = KIND_ALLOC;
      req.block_index = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Fixed mode from the start: one growth to the initial size, then exhaustion.
      write_growth_fixed(1'b1);
      send_item(KIND_FREE, 8'd0);
      send_item(KIND_FREE, 8'd255);
      send_item(KIND_ALLOC, 8'd255);
      for (int n = 0; n < 15; n++) send_item(KIND_ALLOC, INDEX_W'(n));
      send_item(KIND_ALLOC, 8'd0);
      send_item(KIND_FREE, INDEX_W'(DEF_INITIAL_BLOCKS));
      send_item(KIND_FREE, 8'd255);
      send_item(KIND_FREE, 8'd15);
      send_item(KIND_FREE, 8'd0);
      send_item(KIND_ALLOC, 8'd170);
      send_item(KIND_ALLOC, 8'd85);

      run_phase(1'b0, 0, 0, 75, 110, 0);
      run_phase(1'b1, 73, 0, 70, 90, 0);
      run_phase(1'b0, 0, 73, 90, 110, 0);
      run_phase(1'b0, 18, 18, 95, 120, 300);
      run_phase(1'b1, 0, 0, 30, 110, 0);
      run_phase(1'b0, 18, 18, 50, 100, 0);

      // A double free corrupts the list for good, so it closes the run.
      req.valid <= 1'b0;
      wait_for_results();
      write_growth_fixed(1'b0);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      if (pool.granted_blocks.size() == 0) send_item(KIND_ALLOC, 8'd0);
      if (pool.granted_blocks.size() > 0) begin
         victim = pool.granted_blocks[$];
         send_item(KIND_FREE, victim);
         send_item(KIND_FREE, victim);
         send_item(KIND_ALLOC, 8'd0);
         send_item(KIND_ALLOC, 8'd0);
      end
      req.valid <= 1'b0;

      wait_for_results();
      guard = 0;
      while (guard < 20) begin
         @(posedge clock);
         guard++;
      end
      if (pool.errors == 0 && pool.due_results.size() == 0) begin
         $display("[fixed_block_pool_free_list_core] OK");
      end else begin
         if (pool.due_results.size() > 0)
            $display("%0t: %0d result items never arrived", $time, pool.due_results.size());
         $display("[fixed_block_pool_free_list_core] ERROR");
      end
      $finish;
   end

endmodule
`default_nettype wire
